/* rtl/core/fcac_pkg.sv */
// Shared types, codes and the byte-wise CRC-16 step for the frame checksum block.
// No dependencies; used by every other file of the block.
`default_nettype none

package fcac_pkg;

   // configuration register indexes
   localparam logic CSR_CHECKSUM_KIND  = 1'b0;
   localparam logic CSR_OPERATION_MODE = 1'b1;

   // checksum_kind codes
   localparam logic KIND_CRC16 = 1'b0;
   localparam logic KIND_XOR8  = 1'b1;

   // operation_mode codes
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_CHECK  = 1'b1;

   // CRC-16 CCITT polynomial, MSB first
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // saturation limit of the per-frame byte count
   localparam logic [1:0] SEEN_MAX = 2'd3;

   // bytes of trailer per checksum kind
   localparam logic [1:0] CRC16_TRAILER = 2'd2;
   localparam logic [1:0] XOR8_TRAILER  = 2'd1;

   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_PASS  = 2'd1,
      VERDICT_FAIL  = 2'd2,
      VERDICT_SHORT = 2'd3
   } verdict_type;

   // one result transfer
   typedef struct packed {
      logic [7:0]  out_byte;
      verdict_type verdict;
      logic        result_last;
   } result_type;

   // all results caused by one input byte, emitted r0 first
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
      result_type r2;
   } bundle_type;

   // one byte through the CRC register, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/fcac_core.sv */
// Running checksum state and result builder: one byte per accepted transfer.
// Depends on fcac_pkg.
`default_nettype none

module fcac_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 frame_end,
   input  wire logic                 checksum_kind,
   input  wire logic                 operation_mode,
   output fcac_pkg::bundle_type      bundle
);

   logic [15:0] sum_ff, sum_in, sum_upd;
   logic [1:0]  seen_ff, seen_in, seen_upd;
   logic [1:0]  need;
   fcac_pkg::verdict_type verdict;

   // checksum and byte count after this byte
   always_comb begin
      if (checksum_kind == fcac_pkg::KIND_XOR8) begin
         sum_upd = {8'h00, sum_ff[7:0] ^ data_byte};
         need    = fcac_pkg::XOR8_TRAILER;
      end else begin
         sum_upd = fcac_pkg::crc_byte(sum_ff, data_byte);
         need    = fcac_pkg::CRC16_TRAILER;
      end
      seen_upd = (seen_ff == fcac_pkg::SEEN_MAX) ? seen_ff : seen_ff + 2'd1;
   end

   // check verdict: residue over the whole frame must be zero
   always_comb begin
      if (seen_upd < need) begin
         verdict = fcac_pkg::VERDICT_SHORT;
      end else if (sum_upd == 16'h0000) begin
         verdict = fcac_pkg::VERDICT_PASS;
      end else begin
         verdict = fcac_pkg::VERDICT_FAIL;
      end
   end

   // results for this byte
   always_comb begin
      bundle = '0;
      if (operation_mode == fcac_pkg::MODE_APPEND) begin
         bundle.count = 2'd1;
         bundle.r0    = '{data_byte, fcac_pkg::VERDICT_NONE, 1'b0};
         if (frame_end) begin
            if (checksum_kind == fcac_pkg::KIND_XOR8) begin
               bundle.count = 2'd2;
               bundle.r1    = '{sum_upd[7:0], fcac_pkg::VERDICT_NONE, 1'b1};
            end else begin
               bundle.count = 2'd3;
               bundle.r1    = '{sum_upd[15:8], fcac_pkg::VERDICT_NONE, 1'b0};
               bundle.r2    = '{sum_upd[7:0], fcac_pkg::VERDICT_NONE, 1'b1};
            end
         end
      end else if (frame_end) begin
         bundle.count = 2'd1;
         bundle.r0    = '{8'h00, verdict, 1'b1};
      end
   end

   // state clears after every frame end
   always_comb begin
      sum_in  = sum_ff;
      seen_in = seen_ff;
      if (accept) begin
         sum_in  = frame_end ? 16'h0000 : sum_upd;
         seen_in = frame_end ? 2'd0 : seen_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         seen_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fcac_emit.sv */
// Output register: holds the results of one byte and sends them one per transfer.
// Depends on fcac_pkg.
`default_nettype none

module fcac_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire fcac_pkg::bundle_type bundle,
   output logic                      free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output fcac_pkg::result_type      result
);

   logic                 valid_ff, valid_in;
   logic [1:0]           idx_ff, idx_in;
   fcac_pkg::bundle_type held_ff, held_in;
   logic                 done;

   assign rsp_tvalid = valid_ff;

   // current result by position
   always_comb begin
      case (idx_ff)
         2'd0:    result = held_ff.r0;
         2'd1:    result = held_ff.r1;
         default: result = held_ff.r2;
      endcase
   end

   // last held result leaves this cycle
   assign done = valid_ff && rsp_tready && (idx_ff == held_ff.count - 2'd1);
   assign free = !valid_ff || done;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      held_in  = held_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
         held_in  = bundle;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_tready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

/* rtl/core/frame_checksum_append_check.sv */
// Top level of the frame checksum appender and checker.
// Depends on fcac_pkg, fcac_core and fcac_emit.
`default_nettype none

// Takes one message byte per transfer, last byte marked by req_tlast, and keeps a
// running CRC-16 CCITT (poly 0x1021, init 0, no final XOR) or XOR-8 checksum.
// Append mode echoes each byte and, after the last, sends the trailer (CRC high
// then low byte, or the XOR byte). Check mode sends nothing until the last byte,
// then one verdict in rsp_tuser (1 correct, 2 wrong, 3 too short). rsp_tlast marks
// the final result of a frame. A byte is taken every cycle as long as its results
// can leave at one per cycle: while rsp_tready is high, bytes that cause one result
// or none sustain one byte per cycle, and a last byte in append mode holds the input
// while the single output register drains. A byte's first result is valid in the cycle
// after its transfer. Configuration must be written while idle; the block does not enforce it.
module frame_checksum_append_check (
   input  wire logic       clock,
   input  wire logic       reset,
   // input stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // frame_end
   // result stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [1:0] verdict
   output logic            rsp_tlast,   // result_last
   // configuration writes
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic       csr_wdata
);

   logic                 kind_ff, kind_in;
   logic                 mode_ff, mode_in;
   logic                 accept;
   logic                 free;
   fcac_pkg::bundle_type bundle;
   fcac_pkg::result_type result;

   // register writes
   always_comb begin
      kind_in = kind_ff;
      mode_in = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            fcac_pkg::CSR_CHECKSUM_KIND:  kind_in = csr_wdata;
            fcac_pkg::CSR_OPERATION_MODE: mode_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= fcac_pkg::KIND_CRC16;
         mode_ff <= fcac_pkg::MODE_APPEND;
      end else begin
         kind_ff <= kind_in;
         mode_ff <= mode_in;
      end
   end

   // input transfer whenever the output register frees up this cycle
   assign req_tready = free;
   assign accept     = req_tvalid && req_tready;

   fcac_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_tdata),
      .frame_end      (req_tlast),
      .checksum_kind  (kind_ff),
      .operation_mode (mode_ff),
      .bundle         (bundle)
   );

   fcac_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && (bundle.count != 2'd0)),
      .bundle     (bundle),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = result.out_byte;
   assign rsp_tuser = result.verdict;
   assign rsp_tlast = result.result_last;

endmodule

`default_nettype wire

/* tb/frame_checksum_append_check_tb.sv */
// Self-checking testbench for frame_checksum_append_check: echo/trailer and verdict streams.
// Depends on fcac_pkg and the block's RTL; a scoreboard class tracks the CRC/XOR state.
`timescale 1ns / 1ps

// Tracks the block's checksum state and holds the results each accepted byte must cause
class checksum_tracker;
   logic                     kind;
   logic                     mode;
   logic [15:0]              run_sum;
   logic [1:0]               seen;
   fcac_pkg::result_type     results_due[$];
   int                       failures;

   function new();
      kind     = fcac_pkg::KIND_CRC16;
      mode     = fcac_pkg::MODE_APPEND;
      run_sum  = 16'h0000;
      seen     = 2'd0;
      failures = 0;
   endfunction

   // bit-serial CRC-16 CCITT, MSB of the byte first
   function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ b[i];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ fcac_pkg::CRC_POLY;
         end
      end
      return crc;
   endfunction

   function void note_write(logic index, logic value);
      if (index == fcac_pkg::CSR_CHECKSUM_KIND) begin
         kind = value;
      end else begin
         mode = value;
      end
   endfunction

   function void queue_result(logic [7:0] b, fcac_pkg::verdict_type v, logic last);
      fcac_pkg::result_type r;
      r.out_byte    = b;
      r.verdict     = v;
      r.result_last = last;
      results_due.push_back(r);
   endfunction

   function void flag(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // one accepted input byte
   function void take_byte(logic [7:0] b, logic last);
      logic [1:0]           need;
      fcac_pkg::verdict_type v;
      if (kind == fcac_pkg::KIND_XOR8) begin
         run_sum = {8'h00, run_sum[7:0] ^ b};
      end else begin
         run_sum = crc_step(run_sum, b);
      end
      if (seen != fcac_pkg::SEEN_MAX) begin
         seen = seen + 2'd1;
      end

      if (mode == fcac_pkg::MODE_APPEND) begin
         queue_result(b, fcac_pkg::VERDICT_NONE, 1'b0);
         if (last) begin
            if (kind == fcac_pkg::KIND_XOR8) begin
               queue_result(run_sum[7:0], fcac_pkg::VERDICT_NONE, 1'b1);
            end else begin
               queue_result(run_sum[15:8], fcac_pkg::VERDICT_NONE, 1'b0);
               queue_result(run_sum[7:0], fcac_pkg::VERDICT_NONE, 1'b1);
            end
         end
      end else if (last) begin
         need = (kind == fcac_pkg::KIND_XOR8) ? fcac_pkg::XOR8_TRAILER
                                              : fcac_pkg::CRC16_TRAILER;
         if (seen < need) begin
            v = fcac_pkg::VERDICT_SHORT;
         end else if (run_sum == 16'h0000) begin
            v = fcac_pkg::VERDICT_PASS;
         end else begin
            v = fcac_pkg::VERDICT_FAIL;
         end
         queue_result(8'h00, v, 1'b1);
      end

      // frame end clears the running state
      if (last) begin
         run_sum = 16'h0000;
         seen    = 2'd0;
      end
   endfunction

   // one accepted result transfer, against the oldest one due
   function void match_result(logic [7:0] b, logic [1:0] v, logic last);
      fcac_pkg::result_type e;
      if (results_due.size() == 0) begin
         flag($sformatf("unexpected result: byte %h verdict %0d last %b", b, v, last));
      end else begin
         e = results_due.pop_front();
         if (b !== e.out_byte || v !== e.verdict || last !== e.result_last) begin
            flag($sformatf("mismatch: expected byte %h verdict %0d last %b, got %h %0d %b",
                           e.out_byte, e.verdict, e.result_last, b, v, last));
         end
      end
   endfunction

   function void drain_check();
      if (results_due.size() != 0) begin
         flag($sformatf("%0d results never arrived", results_due.size()));
      end
   endfunction
endclass

module frame_checksum_append_check_tb;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;     // [7:0] data_byte
   logic       req_tlast;     // frame_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;     // [7:0] out_byte
   logic [1:0] rsp_tuser;     // [1:0] verdict
   logic       rsp_tlast;     // result_last
   logic       csr_we;
   logic       csr_index;
   logic       csr_wdata;

   checksum_tracker sb;
   logic [7:0]      frame_bytes[$];
   int              burst_left = 0;
   int              items_sent = 0;
   int              stall_run = 0;
   int              stall_style = 0;

   frame_checksum_append_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: runs of full ready, random stalls and mostly-stalled stretches
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_run   = $urandom_range(10, 60);
      end
      stall_run--;
      case (stall_style)
         0: begin
            rsp_tready = 1'b1;
         end
         1: begin
            rsp_tready = 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready = ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.match_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer, valid left high
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) begin
               req_tdata = 8'($urandom);
               req_tlast = 1'($urandom_range(0, 1));
               @(negedge clock);
            end
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.take_byte(b, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   task automatic make_random(input int len);
      frame_bytes.delete();
      repeat (len) begin
         frame_bytes.push_back(8'($urandom));
      end
   endtask

   // trailer for the current checksum kind, so the residue over the frame is zero
   task automatic append_trailer();
      logic [15:0] s;
      s = 16'h0000;
      foreach (frame_bytes[i]) begin
         if (sb.kind == fcac_pkg::KIND_XOR8) begin
            s = {8'h00, s[7:0] ^ frame_bytes[i]};
         end else begin
            s = sb.crc_step(s, frame_bytes[i]);
         end
      end
      if (sb.kind == fcac_pkg::KIND_XOR8) begin
         frame_bytes.push_back(s[7:0]);
      end else begin
         frame_bytes.push_back(s[15:8]);
         frame_bytes.push_back(s[7:0]);
      end
   endtask

   // flip one bit somewhere in the frame
   task automatic corrupt_frame();
      int idx;
      idx = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
   endtask

   task automatic write_reg(input logic index, input logic value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      sb.note_write(index, value);
      @(negedge clock);
      csr_we    = 1'b0;
      csr_index = 1'($urandom_range(0, 1));
      csr_wdata = 1'($urandom_range(0, 1));
   endtask

   // drain all results, let the pipeline settle, then reconfigure
   task automatic set_phase(input logic kind, input logic mode);
      req_tvalid = 1'b0;
      while (sb.results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      write_reg(fcac_pkg::CSR_CHECKSUM_KIND, kind);
      write_reg(fcac_pkg::CSR_OPERATION_MODE, mode);
   endtask

   initial begin
      int len;
      int pick;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed: CRC append, single-byte frame and extreme bytes
      set_phase(fcac_pkg::KIND_CRC16, fcac_pkg::MODE_APPEND);
      frame_bytes = '{8'h00};
      send_frame();
      frame_bytes = '{8'hff, 8'h00, 8'hff};
      send_frame();

      // XOR append
      set_phase(fcac_pkg::KIND_XOR8, fcac_pkg::MODE_APPEND);
      frame_bytes = '{8'hff};
      send_frame();
      frame_bytes = '{8'h5a, 8'ha5};
      send_frame();

      // CRC check: too short, good trailers, bad frame, long frame past the count limit
      set_phase(fcac_pkg::KIND_CRC16, fcac_pkg::MODE_CHECK);
      frame_bytes = '{8'h55};
      send_frame();
      frame_bytes = '{8'h00, 8'h00};
      send_frame();
      frame_bytes = '{8'hff};
      append_trailer();
      send_frame();
      frame_bytes = '{8'h31, 8'h32, 8'h33};
      send_frame();
      make_random(4);
      append_trailer();
      send_frame();

      // XOR check: single byte is never short
      set_phase(fcac_pkg::KIND_XOR8, fcac_pkg::MODE_CHECK);
      frame_bytes = '{8'h00};
      send_frame();
      frame_bytes = '{8'hff};
      send_frame();
      frame_bytes = '{8'h12, 8'h12};
      send_frame();

      // random phases, mostly well-formed frames in check mode
      items_sent = 0;
      while (items_sent < 300) begin
         set_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         repeat ($urandom_range(3, 8)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            make_random(len);
            if (sb.mode == fcac_pkg::MODE_CHECK) begin
               pick = $urandom_range(0, 7);
               if (pick < 6) begin
                  append_trailer();
               end
               if (pick == 5) begin
                  corrupt_frame();
               end
            end
            send_frame();
         end
      end

      // drain and settle
      req_tvalid = 1'b0;
      for (int w = 0; w < 20000 && sb.results_due.size() != 0; w++) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      sb.drain_check();
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/fcac_pkg.sv
rtl/core/fcac_core.sv
rtl/core/fcac_emit.sv
rtl/core/frame_checksum_append_check.sv
tb/frame_checksum_append_check_tb.sv
